// File: design/brlt_pkg.sv
package brlt_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_RECIP,
    ST_QN,
    ST_HOME,
    ST_PROBE,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  localparam logic CMD_ISSUE = 1'b0;
  localparam logic CMD_DONE  = 1'b1;

  localparam logic [63:0] HASH_MULT    = 64'h9E37_79B9_7F4A_7C15;
  localparam int          SECTOR_SHIFT = 9;
  localparam logic [7:0]  CHAR_SYNC    = 8'h53;
  localparam logic [7:0]  CHAR_FUA     = 8'h46;

  typedef struct packed {
    logic        valid;
    logic [63:0] sector;
    logic [63:0] start_ns;
  } entry_t;

endpackage

// File: design/block_request_latency_tracker_unit.sv
// A completion that hits gives its result word on m_axis after the input word is accepted
// and has passed the hash steps (MUL, SUM, RECIP, QN, HOME), PROBE_LIMIT table reads, the
// drain step and the update step, which waits while m_axis holds a word not yet taken. No new
// input word is accepted until the previous one is done; the table is read once per probed slot.
// Reset: rst clears control state, then a clearing pass writes every table entry invalid;
// no input word is accepted until it ends.
module block_request_latency_tracker_unit
  import brlt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024,
  parameter int PROBE_LIMIT   = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sector[63:0], now_ns[127:64], device[159:128], sector_count[183:160],
  // process_id[215:184], op_char[223:216], flag_char_one[231:224],
  // flag_char_two[239:232], flag_char_three[247:240]
  input  logic [247:0] s_axis_tdata,
  // command[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // done_time_ns[63:0], latency[127:64], out_sector[191:128], out_device[223:192],
  // byte_count[256:224], out_process[288:257], op_code[296:289], zeros[303:297]
  output logic [303:0] m_axis_tdata
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PCNT_W = $clog2(PROBE_LIMIT + 1);
  localparam logic [32:0]       RECIP     = 33'((64'd1 << 32) / TABLE_ENTRIES);
  localparam logic [16:0]       ENTRIES_K = 17'(TABLE_ENTRIES);
  localparam logic [31:0]       ENTRIES_W = 32'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [PCNT_W-1:0] LAST_PROBE = PCNT_W'(PROBE_LIMIT - 1);

  state_t state, state_next;

  // Captured input word.
  logic        cmd_q;
  logic [63:0] sector_q;
  logic [63:0] now_q;
  logic [31:0] device_q;
  logic [23:0] count_q;
  logic [31:0] pid_q;
  logic [7:0]  op_q;

  // Hash pipeline registers.
  logic [63:0] p_ll;
  logic [31:0] p_hl;
  logic [31:0] p_lh;
  logic [31:0] hash_h;
  logic [31:0] quot;
  logic [31:0] qn_low;

  // Probe bookkeeping.
  logic [IDX_W-1:0]  probe_slot;
  logic [PCNT_W-1:0] probe_cnt;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_slot;
  entry_t            rd_data;
  logic              hit_found;
  logic [IDX_W-1:0]  hit_slot;
  logic [63:0]       hit_start;
  logic              free_found;
  logic [IDX_W-1:0]  free_slot;

  logic [IDX_W-1:0] clr_addr;

  // Table memory.
  entry_t           table_mem [TABLE_ENTRIES];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // Control decoded from state.
  logic out_free;
  logic out_load;
  logic stall_out;
  logic issue_write;

  logic [31:0] xl;
  logic [63:0] mul_ll;
  logic [63:0] mul_hl;
  logic [63:0] mul_lh;
  logic [64:0] mul_recip;
  logic [48:0] mul_qn;
  logic [31:0] rem_raw;
  logic [31:0] rem_fix;
  logic        in_sync;
  logic [IDX_W-1:0] probe_next;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Low half of key * HASH_MULT, bits 63:32, from three 32-bit partial products.
  assign xl     = sector_q[31:0] ^ sector_q[63:32];
  assign mul_ll = 64'(xl) * 64'(HASH_MULT[31:0]);
  assign mul_hl = 64'(sector_q[63:32]) * 64'(HASH_MULT[31:0]);
  assign mul_lh = 64'(xl) * 64'(HASH_MULT[63:32]);

  // Remainder by the table size through a reciprocal; the estimate is low by at most one.
  assign mul_recip = 65'(hash_h) * 65'(RECIP);
  assign mul_qn    = 49'(quot) * 49'(ENTRIES_K);
  assign rem_raw   = hash_h - qn_low;
  assign rem_fix   = (rem_raw >= ENTRIES_W) ? rem_raw - ENTRIES_W : rem_raw;

  assign in_sync = (s_axis_tdata[231:224] == CHAR_SYNC) || (s_axis_tdata[231:224] == CHAR_FUA)
                || (s_axis_tdata[239:232] == CHAR_SYNC) || (s_axis_tdata[239:232] == CHAR_FUA)
                || (s_axis_tdata[247:240] == CHAR_SYNC) || (s_axis_tdata[247:240] == CHAR_FUA);

  assign probe_next = (probe_slot == LAST_SLOT) ? '0 : probe_slot + 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr == LAST_SLOT) state_next = ST_IDLE;
      ST_IDLE:   if (s_axis_tvalid) state_next = ST_MUL;
      ST_MUL:    state_next = ST_SUM;
      ST_SUM:    state_next = ST_RECIP;
      ST_RECIP:  state_next = ST_QN;
      ST_QN:     state_next = ST_HOME;
      ST_HOME:   state_next = ST_PROBE;
      ST_PROBE:  if (probe_cnt == LAST_PROBE) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_DECIDE;
      ST_DECIDE: if (!stall_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    stall_out     = 1'b0;
    issue_write   = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = hit_found ? hit_slot : free_slot;
    mem_wdata     = '{valid: 1'b0, sector: sector_q, start_ns: now_q};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      ST_IDLE: s_axis_tready = 1'b1;
      ST_DECIDE: begin
        if (cmd_q == CMD_ISSUE) begin
          issue_write = (sector_q != 64'd0) && (hit_found || free_found);
          mem_we      = issue_write;
          mem_wdata.valid = 1'b1;
        end else if (hit_found) begin
          stall_out = !out_free;
          out_load  = out_free;
          mem_we    = out_free;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      rd_vld        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_PROBE);
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q    <= s_axis_tuser;
      sector_q <= s_axis_tdata[63:0];
      now_q    <= s_axis_tdata[127:64];
      device_q <= s_axis_tdata[159:128];
      count_q  <= s_axis_tdata[183:160];
      pid_q    <= s_axis_tdata[215:184];
      op_q     <= in_sync ? CHAR_SYNC : s_axis_tdata[223:216];
    end
    if (state == ST_MUL) begin
      p_ll <= mul_ll;
      p_hl <= mul_hl[31:0];
      p_lh <= mul_lh[31:0];
    end
    if (state == ST_SUM)   hash_h <= p_ll[63:32] + p_hl + p_lh;
    if (state == ST_RECIP) quot   <= mul_recip[63:32];
    if (state == ST_QN)    qn_low <= mul_qn[31:0];
    if (state == ST_HOME) begin
      probe_slot <= IDX_W'(rem_fix);
      probe_cnt  <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_PROBE) begin
      probe_slot <= probe_next;
      probe_cnt  <= probe_cnt + 1'b1;
    end
    rd_slot <= probe_slot;
    // Keep the first matching slot and the first free slot of the probe run.
    if (rd_vld) begin
      if (rd_data.valid && (rd_data.sector == sector_q) && !hit_found) begin
        hit_found <= 1'b1;
        hit_slot  <= rd_slot;
        hit_start <= rd_data.start_ns;
      end
      if (!rd_data.valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_slot;
      end
    end
    if (out_load) begin
      m_axis_tdata <= {7'd0, op_q, pid_q, {count_q, {SECTOR_SHIFT{1'b0}}}, device_q,
                       sector_q, now_q - hit_start, now_q};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) table_mem[mem_waddr] <= mem_wdata;
    rd_data <= table_mem[probe_slot];
  end

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DECIDE))
    else $error("result word raised outside the update step");

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == ST_DECIDE)) |-> (hit_found || free_found))
    else $error("table write without a chosen slot");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> rd_vld)
    else $error("drain step reached without the last probe read");

endmodule
